[hdl/ovl_pkg.sv]
package ovl_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_MISSING = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [3:0] position;
        logic [4:0] count;
    } out_item_t;

    typedef struct packed {
        logic write;
        logic compare;
        logic skip_head;
        logic scan;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } ovl_state_t;

endpackage

[hdl/ovl_cell.sv]
module ovl_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ovl_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]        key,
    input  logic [CNT_W-1:0]   count,
    input  logic [CNT_W-1:0]   shift_pos,
    input  logic [31:0]        next_value,
    input  logic               next_match,
    output logic [31:0]        value,
    output logic               match
);
    import ovl_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);

    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic        match_reg;
    logic        match_next;
    logic        occupied;

    assign occupied = (count > IDX_C);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.write && (count == IDX_C))
        begin
            value_next = key;
        end
        else if (ctrl.shift && (IDX_C >= shift_pos))
        begin
            value_next = next_value;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.compare)
        begin
            match_next = occupied && (value_reg == key) && !(ctrl.skip_head && (INDEX == 0));
        end
        else if (ctrl.scan)
        begin
            match_next = next_match;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

[hdl/ordered_value_list.sv]
// Insert: S_CMP writes the item unless the list is full; S_DONE registers the result.
// Search and delete: a compare step (S_CMP), then a scan (S_SCAN) over the positions
// until the first match or the last entry (a delete takes a head match only if none
// follows), a shift to close the gap on a delete hit, and S_DONE for the result.
// One item is in work at a time; the next is taken once the result is registered.
// Reset clears the entry count and the control state; stored values are not cleared.
module ordered_value_list #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ovl_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ovl_pkg::out_item_t  out_item
);
    import ovl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    ovl_state_t       state_reg;
    ovl_state_t       state_next;
    logic [1:0]       cmd_reg;
    logic [1:0]       cmd_next;
    logic [31:0]      key_reg;
    logic [31:0]      key_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] scan_next;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] pos_next;
    logic             head_hit_reg;
    logic             head_hit_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic             found_reg;
    logic             found_next;
    out_item_t        out_reg;
    out_item_t        out_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    cell_ctrl_t       ctrl;
    logic [31:0]      value_chain [0:DEPTH];
    logic             match_chain [0:DEPTH];
    logic             scan_last;
    logic [CNT_W:0]   scan_inc;
    logic             slot_free;
    logic [EXT_W-1:0] count_ext;
    logic [EXT_W-1:0] pos_ext;

    assign value_chain[DEPTH] = '0;
    assign match_chain[DEPTH] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ovl_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (key_reg),
            .count      (count_reg),
            .shift_pos  (pos_reg),
            .next_value (value_chain[i+1]),
            .next_match (match_chain[i+1]),
            .value      (value_chain[i]),
            .match      (match_chain[i])
        );
    end

    assign scan_inc  = {1'b0, scan_reg} + 1'b1;
    assign scan_last = (scan_inc >= {1'b0, count_reg});
    assign slot_free = !out_valid_reg || out_ready;
    assign count_ext = EXT_W'(count_reg);
    assign pos_ext   = EXT_W'(pos_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if ((cmd_reg == CMD_DELETE) || (cmd_reg == CMD_SEARCH))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (match_chain[0])
                begin
                    state_next = (cmd_reg == CMD_DELETE) ? S_SHIFT : S_DONE;
                end
                else if (scan_last)
                begin
                    state_next = ((cmd_reg == CMD_DELETE) && head_hit_reg) ? S_SHIFT : S_DONE;
                end
            end
            S_SHIFT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        ctrl           = '0;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        pos_next       = pos_reg;
        head_hit_next  = head_hit_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = in_item.cmd;
                    key_next = in_item.value;
                end
            end
            S_CMP:
            begin
                scan_next     = '0;
                pos_next      = '0;
                found_next    = 1'b0;
                status_next   = STATUS_OK;
                head_hit_next = (count_reg != '0) && (value_chain[0] == key_reg);
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ctrl.write = 1'b1;
                            pos_next   = count_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_DELETE:
                    begin
                        ctrl.compare   = 1'b1;
                        ctrl.skip_head = 1'b1;
                    end
                    CMD_SEARCH:
                    begin
                        ctrl.compare = 1'b1;
                    end
                    default:
                    begin
                        status_next = STATUS_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                ctrl.scan = 1'b1;
                scan_next = scan_inc[CNT_W-1:0];
                if (match_chain[0])
                begin
                    pos_next    = scan_reg;
                    found_next  = 1'b1;
                    status_next = STATUS_OK;
                end
                else if (scan_last)
                begin
                    if ((cmd_reg == CMD_DELETE) && head_hit_reg)
                    begin
                        pos_next    = '0;
                        found_next  = 1'b1;
                        status_next = STATUS_OK;
                    end
                    else
                    begin
                        pos_next    = '0;
                        found_next  = 1'b0;
                        status_next = STATUS_MISSING;
                    end
                end
            end
            S_SHIFT:
            begin
                ctrl.shift = 1'b1;
                count_next = count_reg - 1'b1;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_next.status   = status_reg;
                    out_next.found    = found_reg;
                    out_next.position = pos_ext[3:0];
                    out_next.count    = count_ext[4:0];
                    out_valid_next    = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        scan_reg     <= scan_next;
        pos_reg      <= pos_next;
        head_hit_reg <= head_hit_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule
